// ===== sv/mspt_pkg.sv =====
// Package for the multi-slot periodic timer queue.
// Holds operation codes, arithmetic constants and the controller/datapath structs.
`timescale 1ns / 1ps
package mspt_pkg;

   // Operation codes carried in req_func
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_SET   = 2'd1;
   localparam logic [1:0] FUNC_KILL  = 2'd2;
   localparam logic [1:0] FUNC_CHECK = 2'd3;

   // Milliseconds per tick and its reciprocal: floor(2^22 / 55)
   localparam int          TICKS_W     = 11;
   localparam logic [5:0]  MS_PER_TICK = 6'd55;
   localparam logic [16:0] TICK_RECIP  = 17'd76260;
   localparam int          RECIP_SHIFT = 22;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // latch transaction, clear result, start counters
      logic ord_rd;     // read activation order at walk index
      logic tmr_rd;     // read timer entry of slot just fetched from order
      logic tmr_upd;    // count down or expire and reload
      logic div_step;   // first step of period / 55
      logic set_fix;    // correct quotient, write timer, append to order
      logic kord_chk;   // kill: compare and shift order entry
      logic kill_fin;   // kill: disarm slot, drop count
      logic fifo_rd;    // read queue entry at scan index
      logic fifo_chk;   // kill: void matching entry, advance scan
      logic pop;        // check: advance head, report live entry
      logic load_rsp;   // move result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic [1:0] func;
      logic       slot_ok;
      logic       slot_armed;
      logic       armed_zero;
      logic       last_k;
      logic       scan_empty;
      logic       scan_last;
      logic       out_free;
   } sts_type;

endpackage

// ===== sv/multi_slot_periodic_timer_queue.sv =====
// Top level of the multi-slot periodic timer queue.
// Depends on mspt_pkg, mspt_ctrl and mspt_dpath.
//
//   Channel  Ports                                   Direction
//   request  req_valid req_stall req_func/slot/...   in
//   response rsp_valid rsp_stall rsp_event_*/...     out
//
// One transaction at a time. Tick reads and updates each armed slot in turn, set
// divides and then writes the slot, check reads and pops the ring head, and kill walks
// the order list and then scans the queued entries, all through the single-port order,
// timer and ring memories; a stalled response holds back the loading of the next result.
// Synchronous reset clears flags, pointers and counts; memories are not cleared.
// A stalled response holds; the next request is still taken meanwhile.
`timescale 1ns / 1ps
module multi_slot_periodic_timer_queue
   import mspt_pkg::*;
#(
   parameter int TIMER_SLOTS = 16,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_period_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_valid,
   output logic [3:0]  rsp_event_slot,
   output logic        rsp_queue_overflow,
   output logic [15:0] rsp_elapsed_ticks
);

   cmd_type cmd;
   sts_type sts;

   mspt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mspt_dpath #(
      .TIMER_SLOTS (TIMER_SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_slot           (req_slot),
      .req_period_ms      (req_period_ms),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_event_slot     (rsp_event_slot),
      .rsp_queue_overflow (rsp_queue_overflow),
      .rsp_elapsed_ticks  (rsp_elapsed_ticks)
   );

endmodule

// ===== sv/mspt_ctrl.sv =====
// Controller state machine for the multi-slot periodic timer queue.
// Depends on mspt_pkg; drives the datapath through cmd_type only.
`timescale 1ns / 1ps
module mspt_ctrl
   import mspt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_T_ORD, ST_T_TMR, ST_T_UPD, ST_S_DIV, ST_S_FIX,
      ST_K_RD, ST_K_CHK, ST_K_FIN, ST_F_RD, ST_F_CHK, ST_C_RD, ST_C_POP, ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            unique case (sts.func)
               FUNC_TICK:  state_in = sts.armed_zero ? ST_FINISH : ST_T_ORD;
               FUNC_SET:   state_in = sts.slot_ok ? ST_S_DIV : ST_FINISH;
               FUNC_KILL:  state_in = (sts.slot_ok && sts.slot_armed) ? ST_K_RD : ST_FINISH;
               FUNC_CHECK: state_in = sts.scan_empty ? ST_FINISH : ST_C_RD;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_T_ORD:  state_in = ST_T_TMR;
         ST_T_TMR:  state_in = ST_T_UPD;
         ST_T_UPD:  state_in = sts.last_k ? ST_FINISH : ST_T_ORD;
         ST_S_DIV:  state_in = ST_S_FIX;
         ST_S_FIX:  state_in = ST_FINISH;
         ST_K_RD:   state_in = ST_K_CHK;
         ST_K_CHK:  state_in = sts.last_k ? ST_K_FIN : ST_K_RD;
         ST_K_FIN:  state_in = sts.scan_empty ? ST_FINISH : ST_F_RD;
         ST_F_RD:   state_in = ST_F_CHK;
         ST_F_CHK:  state_in = sts.scan_last ? ST_FINISH : ST_F_RD;
         ST_C_RD:   state_in = ST_C_POP;
         ST_C_POP:  state_in = ST_FINISH;
         ST_FINISH: if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands decoded from state
   always_comb begin
      cmd          = '0;
      cmd.accept   = (state_ff == ST_IDLE) && req_valid;
      cmd.ord_rd   = (state_ff == ST_T_ORD) || (state_ff == ST_K_RD);
      cmd.tmr_rd   = (state_ff == ST_T_TMR);
      cmd.tmr_upd  = (state_ff == ST_T_UPD);
      cmd.div_step = (state_ff == ST_S_DIV);
      cmd.set_fix  = (state_ff == ST_S_FIX);
      cmd.kord_chk = (state_ff == ST_K_CHK);
      cmd.kill_fin = (state_ff == ST_K_FIN);
      cmd.fifo_rd  = (state_ff == ST_F_RD) || (state_ff == ST_C_RD);
      cmd.fifo_chk = (state_ff == ST_F_CHK);
      cmd.pop      = (state_ff == ST_C_POP);
      cmd.load_rsp = (state_ff == ST_FINISH) && sts.out_free;
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/mspt_dpath.sv =====
// Datapath for the multi-slot periodic timer queue: slot bank, order list,
// event ring, tick count and response register. Depends on mspt_pkg.
`timescale 1ns / 1ps
module mspt_dpath
   import mspt_pkg::*;
#(
   parameter int TIMER_SLOTS = 16,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_period_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_valid,
   output logic [3:0]  rsp_event_slot,
   output logic        rsp_queue_overflow,
   output logic [15:0] rsp_elapsed_ticks
);

   localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int TW = 2 * TICKS_W;

   function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
      logic [QW-1:0] n;
      n = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
      return n;
   endfunction

   // Latched transaction
   logic [1:0]  func_ff;
   logic [3:0]  slot_ff;
   logic [15:0] ms_ff;
   logic [SW-1:0] sidx;
   logic        slot_ok;

   // Control state
   logic [15:0]          ticks_ff;
   logic [TIMER_SLOTS-1:0] armed_ff, pending_ff;
   logic [CW-1:0]        count_ff, k_ff;
   logic                 found_ff;
   logic [QW-1:0]        head_ff, tail_ff, i_ff;
   logic [SW-1:0]        cur_ff;

   // Memories and their read registers
   logic [SW-1:0]  ord_mem [TIMER_SLOTS];
   logic [TW-1:0]  tmr_mem [TIMER_SLOTS];
   logic [4:0]     fifo_mem [QUEUE_DEPTH];
   logic [SW-1:0]  ord_q_ff;
   logic [TW-1:0]  tmr_q_ff;
   logic [4:0]     fifo_q_ff;

   // Divide and result
   logic [TICKS_W-1:0] q0_ff;
   logic [32:0]        prod;
   logic [16:0]        rem;
   logic [TICKS_W-1:0] quot;
   logic               res_valid_ff, res_ovf_ff;
   logic [3:0]         res_slot_ff;
   logic               rsp_valid_ff;

   // Tick update terms
   logic [TICKS_W-1:0] cd, rl;
   logic [QW-1:0]      nt;
   logic               q_write, q_drop;
   logic [SW-1:0]      es_idx;
   logic               es_ok;

   assign sidx    = SW'(slot_ff);
   assign slot_ok = (32'(slot_ff) < TIMER_SLOTS);
   assign cd      = tmr_q_ff[TICKS_W-1:0];
   assign rl      = tmr_q_ff[TW-1:TICKS_W];
   assign nt      = ring_next(tail_ff);
   assign q_write = (cd == '0) && !pending_ff[cur_ff] && (nt != head_ff);
   assign q_drop  = (cd == '0) && !pending_ff[cur_ff] && (nt == head_ff);
   assign es_idx  = SW'(fifo_q_ff[3:0]);
   assign es_ok   = (32'(fifo_q_ff[3:0]) < TIMER_SLOTS);

   // period / 55: reciprocal product then one correction step
   assign prod = 33'(ms_ff) * 33'(TICK_RECIP);
   assign rem  = 17'(ms_ff) - 17'(q0_ff) * 17'(MS_PER_TICK);
   assign quot = (rem >= 17'(MS_PER_TICK)) ? q0_ff + 1'b1 : q0_ff;

   // Status
   assign sts.func       = func_ff;
   assign sts.slot_ok    = slot_ok;
   assign sts.slot_armed = armed_ff[sidx];
   assign sts.armed_zero = (count_ff == '0);
   assign sts.last_k     = (k_ff + 1'b1 == count_ff);
   assign sts.scan_empty = (i_ff == tail_ff);
   assign sts.scan_last  = (ring_next(i_ff) == tail_ff);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // Transaction latch, counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff     <= '0;
         armed_ff     <= '0;
         pending_ff   <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept && req_func == FUNC_TICK) ticks_ff <= ticks_ff + 1'b1;
         if (cmd.tmr_upd && q_write) begin
            tail_ff             <= nt;
            pending_ff[cur_ff]  <= 1'b1;
         end
         if (cmd.set_fix && !armed_ff[sidx]) begin
            armed_ff[sidx] <= 1'b1;
            if (32'(count_ff) < TIMER_SLOTS) count_ff <= count_ff + 1'b1;
         end
         if (cmd.kill_fin) begin
            armed_ff[sidx]   <= 1'b0;
            pending_ff[sidx] <= 1'b0;
            if (found_ff) count_ff <= count_ff - 1'b1;
         end
         if (cmd.pop) begin
            head_ff <= ring_next(head_ff);
            if (fifo_q_ff[4] && es_ok) pending_ff[es_idx] <= 1'b0;
         end
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff      <= req_func;
         slot_ff      <= req_slot;
         ms_ff        <= req_period_ms;
         k_ff         <= '0;
         found_ff     <= 1'b0;
         i_ff         <= head_ff;
         res_valid_ff <= 1'b0;
         res_slot_ff  <= '0;
         res_ovf_ff   <= 1'b0;
      end
      if (cmd.tmr_rd) cur_ff <= ord_q_ff;
      if (cmd.tmr_upd) begin
         k_ff <= k_ff + 1'b1;
         if (q_drop) res_ovf_ff <= 1'b1;
      end
      if (cmd.kord_chk) begin
         k_ff <= k_ff + 1'b1;
         if (ord_q_ff == sidx) found_ff <= 1'b1;
      end
      if (cmd.fifo_chk) i_ff <= ring_next(i_ff);
      if (cmd.div_step) q0_ff <= prod[RECIP_SHIFT +: TICKS_W];
      if (cmd.pop && fifo_q_ff[4]) begin
         res_valid_ff <= 1'b1;
         res_slot_ff  <= fifo_q_ff[3:0];
      end
      if (cmd.load_rsp) begin
         rsp_event_valid    <= res_valid_ff;
         rsp_event_slot     <= res_slot_ff;
         rsp_queue_overflow <= res_ovf_ff;
         rsp_elapsed_ticks  <= ticks_ff;
      end
   end

   // Activation order memory
   always_ff @(posedge clock) begin
      if (cmd.ord_rd) ord_q_ff <= ord_mem[k_ff[SW-1:0]];
      if (cmd.set_fix && !armed_ff[sidx] && 32'(count_ff) < TIMER_SLOTS) begin
         ord_mem[count_ff[SW-1:0]] <= sidx;
      end else if (cmd.kord_chk && found_ff) begin
         ord_mem[SW'(k_ff - 1'b1)] <= ord_q_ff;
      end
   end

   // Timer memory: reload in the upper half, countdown in the lower
   always_ff @(posedge clock) begin
      if (cmd.tmr_rd) tmr_q_ff <= tmr_mem[ord_q_ff];
      if (cmd.set_fix) begin
         tmr_mem[sidx] <= {quot, quot};
      end else if (cmd.tmr_upd) begin
         tmr_mem[cur_ff] <= (cd == '0) ? {rl, rl} : {rl, cd - 1'b1};
      end
   end

   // Event ring memory
   always_ff @(posedge clock) begin
      if (cmd.fifo_rd) fifo_q_ff <= fifo_mem[i_ff];
      if (cmd.tmr_upd && q_write) begin
         fifo_mem[tail_ff] <= {1'b1, 4'(cur_ff)};
      end else if (cmd.fifo_chk && fifo_q_ff[4] && fifo_q_ff[3:0] == slot_ff) begin
         fifo_mem[i_ff] <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== tb/tb_multi_slot_periodic_timer_queue.sv =====
// Testbench for multi_slot_periodic_timer_queue: directed table, then random traffic.
// Depends on mspt_pkg and the block; a built-in timer-queue predictor checks every response.
`timescale 1ns / 1ps
module tb_multi_slot_periodic_timer_queue;
   import mspt_pkg::*;

   localparam int NSLOT = 16;
   localparam int QDEPTH = 64;
   localparam int RAND_ITEMS = 1830;
   localparam int WDOG_LIMIT = 20000;

   typedef struct packed {
      logic        ev_valid;
      logic [3:0]  ev_slot;
      logic        ovf;
      logic [15:0] ticks;
   } timer_rsp_type;

   typedef struct {
      logic [1:0]    func;
      logic [3:0]    slot;
      logic [15:0]   ms;
      logic          has_exp;
      timer_rsp_type exp;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_TICK;
   logic [3:0]  req_slot = '0;
   logic [15:0] req_period_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_event_valid;
   logic [3:0]  rsp_event_slot;
   logic        rsp_queue_overflow;
   logic [15:0] rsp_elapsed_ticks;

   // predictor state
   logic        armed [NSLOT];
   logic [10:0] reload [NSLOT];
   logic [10:0] cdown [NSLOT];
   logic [3:0]  order [NSLOT];
   int          n_armed;
   logic        pending [NSLOT];
   logic [4:0]  ring [QDEPTH];
   int          head, tail;
   logic [15:0] tick_cnt;

   timer_rsp_type exp_rsp_q[$];
   int            errors = 0;
   int            idle_cycles = 0;
   int            rsp_wait = 0;

   multi_slot_periodic_timer_queue i_dut (.*);

   always #10 clock = ~clock;

   task automatic report(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // apply one transaction to the timer-queue predictor
   function automatic timer_rsp_type predict_timer(input logic [1:0] func, input logic [3:0] s,
                                                   input logic [15:0] ms);
      timer_rsp_type r;
      int            pos, nt, i, k;
      logic [3:0]    cs;
      r = '0;
      case (func)
         FUNC_TICK: begin
            tick_cnt++;
            for (k = 0; k < n_armed; k++) begin
               cs = order[k];
               if (cdown[cs] == 0) begin
                  if (!pending[cs]) begin
                     nt = (tail + 1) % QDEPTH;
                     if (nt == head) r.ovf = 1'b1;
                     else begin
                        ring[tail] = {1'b1, cs};
                        tail = nt;
                        pending[cs] = 1'b1;
                     end
                  end
                  cdown[cs] = reload[cs];
               end else cdown[cs]--;
            end
         end
         FUNC_SET: begin
            reload[s] = 11'(ms / 55);
            cdown[s] = reload[s];
            if (!armed[s]) begin
               armed[s] = 1'b1;
               order[n_armed] = s;
               n_armed++;
            end
         end
         FUNC_KILL: begin
            if (armed[s]) begin
               pos = 0;
               while (order[pos] != s) pos++;
               for (k = pos; k + 1 < n_armed; k++) order[k] = order[k + 1];
               n_armed--;
               armed[s] = 1'b0;
               for (i = head; i != tail; i = (i + 1) % QDEPTH)
                  if (ring[i][4] && ring[i][3:0] == s) ring[i] = '0;
               pending[s] = 1'b0;
            end
         end
         default: begin
            if (head != tail) begin
               if (ring[head][4]) begin
                  r.ev_valid = 1'b1;
                  r.ev_slot = ring[head][3:0];
                  pending[ring[head][3:0]] = 1'b0;
               end
               head = (head + 1) % QDEPTH;
            end
         end
      endcase
      r.ticks = tick_cnt;
      return r;
   endfunction

   // drive one request transaction and queue its expected response
   task automatic send_req(input logic [1:0] func, input logic [3:0] s, input logic [15:0] ms,
                           input logic has_exp, input timer_rsp_type typed);
      timer_rsp_type p;
      int            gap;
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_slot <= s;
      req_period_ms <= ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_timer(func, s, ms);
      if (has_exp && p != typed) report("directed row vs predictor", p, typed);
      exp_rsp_q.push_back(p);
   endtask

   // response side: per-transaction wait, check against oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_rsp_q.size() == 0) report("unexpected response", 1, 0);
            else begin
               timer_rsp_type e;
               e = exp_rsp_q.pop_front();
               if (rsp_event_valid !== e.ev_valid)
                  report("event_valid", rsp_event_valid, e.ev_valid);
               if (rsp_event_slot !== e.ev_slot) report("event_slot", rsp_event_slot, e.ev_slot);
               if (rsp_queue_overflow !== e.ovf)
                  report("queue_overflow", rsp_queue_overflow, e.ovf);
               if (rsp_elapsed_ticks !== e.ticks)
                  report("elapsed_ticks", rsp_elapsed_ticks, e.ticks);
            end
            rsp_wait = $urandom_range(0, 6);
         end else if (rsp_wait > 0) rsp_wait--;
         rsp_stall <= (rsp_wait != 0);
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("** multi_slot_periodic_timer_queue: FAILED **");
         $finish;
      end
   end

   stim_row_type dir_rows[$];

   function automatic stim_row_type row(input logic [1:0] f, input logic [3:0] s,
                                        input logic [15:0] ms, input logic he,
                                        input timer_rsp_type e);
      stim_row_type r;
      r.func = f; r.slot = s; r.ms = ms; r.has_exp = he; r.exp = e;
      return r;
   endfunction

   initial begin
      int         n, mode, k;
      logic [1:0] f;
      logic [3:0] s;
      logic [15:0] ms;
      for (k = 0; k < NSLOT; k++) begin
         armed[k] = 0; pending[k] = 0; reload[k] = 0; cdown[k] = 0; order[k] = 0;
      end
      for (k = 0; k < QDEPTH; k++) ring[k] = 0;
      n_armed = 0; head = 0; tail = 0; tick_cnt = 0;

      // directed rows; expectation typed only where obvious
      dir_rows.push_back(row(FUNC_CHECK, 4'd0, 16'd0, 1, '{0, 0, 0, 0}));      // empty queue
      dir_rows.push_back(row(FUNC_KILL, 4'd5, 16'd0, 1, '{0, 0, 0, 0}));       // kill unarmed
      dir_rows.push_back(row(FUNC_TICK, 4'd15, 16'hFFFF, 1, '{0, 0, 0, 1}));   // no slots
      dir_rows.push_back(row(FUNC_SET, 4'd0, 16'd54, 1, '{0, 0, 0, 1}));       // zero period
      dir_rows.push_back(row(FUNC_SET, 4'd15, 16'hFFFF, 1, '{0, 0, 0, 1}));    // max period
      dir_rows.push_back(row(FUNC_SET, 4'd7, 16'd110, 0, '0));
      dir_rows.push_back(row(FUNC_TICK, 4'd0, 16'd0, 0, '0));
      dir_rows.push_back(row(FUNC_TICK, 4'd0, 16'd0, 0, '0));                  // already pending
      dir_rows.push_back(row(FUNC_TICK, 4'd0, 16'd0, 0, '0));
      dir_rows.push_back(row(FUNC_SET, 4'd7, 16'd55, 0, '0));                  // reload in place
      dir_rows.push_back(row(FUNC_CHECK, 4'd0, 16'd0, 1, '{1, 0, 0, 4}));
      dir_rows.push_back(row(FUNC_TICK, 4'd0, 16'd0, 0, '0));
      dir_rows.push_back(row(FUNC_KILL, 4'd7, 16'd0, 0, '0));                  // voids entry
      dir_rows.push_back(row(FUNC_CHECK, 4'd0, 16'd0, 0, '0));
      dir_rows.push_back(row(FUNC_CHECK, 4'd0, 16'd0, 0, '0));
      dir_rows.push_back(row(FUNC_KILL, 4'd0, 16'd0, 0, '0));
      dir_rows.push_back(row(FUNC_KILL, 4'd15, 16'd0, 0, '0));
      dir_rows.push_back(row(FUNC_CHECK, 4'd0, 16'd0, 0, '0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i])
         send_req(dir_rows[i].func, dir_rows[i].slot, dir_rows[i].ms,
                  dir_rows[i].has_exp, dir_rows[i].exp);

      // random part: phases of short periods with sparse checks drive the ring full
      for (n = 0; n < RAND_ITEMS; n++) begin
         if (n == RAND_ITEMS / 2) begin
            req_valid <= 1'b0;
            wait (exp_rsp_q.size() == 0);
         end
         mode = (n / 300) % 3;
         k = $urandom_range(0, 99);
         s = 4'($urandom);
         if (mode == 1) ms = 16'($urandom_range(0, 200));
         else if ($urandom_range(0, 9) == 0) ms = 16'($urandom);
         else ms = 16'($urandom_range(0, 600));
         if (k < 45) f = FUNC_TICK;
         else if (k < 65) f = FUNC_SET;
         else if (k < (mode == 1 ? 72 : 78)) f = FUNC_KILL;
         else f = (mode == 1 && k < 92) ? FUNC_TICK : FUNC_CHECK;
         send_req(f, s, ms, 0, '0);
      end
      req_valid <= 1'b0;

      wait (exp_rsp_q.size() == 0);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("** multi_slot_periodic_timer_queue: PASSED **");
      else $display("** multi_slot_periodic_timer_queue: FAILED **");
      $finish;
   end

endmodule
